>>> sv/lttb_pkg.sv
// Shared constants for the largest-triangle-three-buckets downsampler.
// Used by the top level and its port checker; depends on nothing.
package lttb_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int MAX_KEPT   = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int ACC_W      = CNT_W + 1;
	localparam int TIME_W     = 48;
	localparam int LEVEL_W    = 16;
	localparam int PT_W       = TIME_W + LEVEL_W;
	localparam int PROD_W     = TIME_W + LEVEL_W;
	localparam int AREA_W     = PROD_W + 1;
	localparam int TGT_W      = 7;
	localparam int TGT_RESET  = 64;
	localparam int ECHO_MAX   = 2;
	localparam int SUM_W      = TIME_W + ADDR_W;
	localparam int LSUM_W     = LEVEL_W + ADDR_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);

endpackage

>>> sv/lttb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
module lttb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/lttb_downsampler_unit.sv
// Largest-triangle-three-buckets downsampler, top level.
// Depends on lttb_pkg and lttb_ram (one point memory holding time and level).
//
// Usage: points arrive on the input channel (in_valid/in_stall) with a time, a
// level and is_last. Outside echo mode each accepted request is written to the
// point memory, one per cycle, until the store is full. The request that carries
// is_last then starts selection; the input is stalled until the last selected
// point is loaded into the output register (out_valid/out_stall). The final
// selected point carries sel_last. Series no longer than target_count (capped
// at MAX_KEPT) are sent back unchanged, each point read from memory and then
// loaded into the output register. Otherwise each bucket mean is summed at one
// point a cycle and then divided by a bit-serial divider, and each candidate
// point goes through a memory read, two multiplies and an area compare.
// With target_count at most 2 each point is echoed through the output register
// the cycle after it is accepted, one per cycle while the output is not stalled.
// A stalled output holds its point; the sequencer waits with it.
// Reset clears the point count and sets target_count to 64; the memory is not
// cleared and needs no clearing pass.
module lttb_downsampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [lttb_pkg::TGT_W-1:0]       cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [lttb_pkg::TIME_W-1:0]      point_time,
	input  logic [lttb_pkg::LEVEL_W-1:0]     point_level,
	input  logic                             is_last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [lttb_pkg::TIME_W-1:0]      sel_time,
	output logic [lttb_pkg::LEVEL_W-1:0]     sel_level,
	output logic                             sel_last
);

	typedef enum logic [3:0] {
		S_LOAD, S_EMIT_RD, S_EMIT_WAIT, S_SETUP_DIV, S_INIT_STEP, S_NEXT,
		S_MEAN_START, S_MSUM, S_MPT_WAIT, S_MDIV, S_SC_RD, S_SC_MUL, S_SC_CMP
	} state_t;

	typedef enum logic [1:0] {PH_PASS, PH_FIRST, PH_INNER, PH_FINAL} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [lttb_pkg::TGT_W-1:0]   target_q, div_q, eff;
	logic [lttb_pkg::CNT_W-1:0]   count_q, n_q, n_new, n_m1;
	logic [lttb_pkg::ADDR_W-1:0]  emit_idx_q;
	logic                         emit_last_q;
	logic                         out_valid_q, sel_last_q;
	logic [lttb_pkg::TIME_W-1:0]  sel_time_q, ax_q, mx_q;
	logic [lttb_pkg::LEVEL_W-1:0] sel_level_q, ay_q, my_q;

	// bucket bound generator
	logic [lttb_pkg::ACC_W-1:0]   bq_q, bq_nx, bnd_raw;
	logic [lttb_pkg::TGT_W-1:0]   br_q, br_nx, rem_q;
	logic [lttb_pkg::TGT_W:0]     r_sum;
	logic                         r_wrap;
	logic [lttb_pkg::ADDR_W-1:0]  quo_q;
	logic [lttb_pkg::CNT_W-1:0]   b0_q, b1_q, b2_q, bnd_new;
	logic [1:0]                   init_cnt_q;
	logic [lttb_pkg::TGT_W-1:0]   bkt_q;

	// mean accumulation and divider
	logic [lttb_pkg::CNT_W-1:0]   k_q;
	logic                         pv_q;
	logic [lttb_pkg::SUM_W-1:0]   sum_t_q;
	logic [lttb_pkg::LSUM_W-1:0]  sum_l_q;
	logic [lttb_pkg::SUM_W-1:0]   dv_a_q, dv_b_q;
	logic [lttb_pkg::CNT_W-1:0]   dv_ra_q, dv_rb_q, dv_d_q, dv_ra_nx, dv_rb_nx;
	logic [lttb_pkg::CNT_W:0]     ta, tb;
	logic                         ta_ge, tb_ge, dv_busy;
	logic [lttb_pkg::DSTEP_W-1:0] dv_cnt_q;

	// area evaluation
	logic [lttb_pkg::TIME_W-1:0]  d1, d3;
	logic [lttb_pkg::LEVEL_W-1:0] d2, d4;
	logic                         n1, n2, neg_q, have_q, better;
	logic [lttb_pkg::PROD_W-1:0]  m1_c, m2_c, m1_q, m2_q;
	logic [lttb_pkg::AREA_W-1:0]  area, best_area_q;
	logic [lttb_pkg::CNT_W-1:0]   best_q, best_cap;

	// memory
	logic                         ram_we, echo, out_free, in_acc, count_full, out_load;
	logic [lttb_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr, mean_j;
	logic [lttb_pkg::PT_W-1:0]    ram_rdata;
	logic [lttb_pkg::TIME_W-1:0]  rd_time;
	logic [lttb_pkg::LEVEL_W-1:0] rd_level;

	lttb_ram #(
		.WIDTH(lttb_pkg::PT_W),
		.DEPTH(lttb_pkg::MAX_POINTS)
	) u_point_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata({point_time, point_level}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_time  = ram_rdata[lttb_pkg::PT_W-1:lttb_pkg::LEVEL_W];
	assign rd_level = ram_rdata[lttb_pkg::LEVEL_W-1:0];

	assign echo       = target_q <= lttb_pkg::TGT_W'(lttb_pkg::ECHO_MAX);
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = !(state_q == S_LOAD && (!echo || out_free));
	assign in_acc     = in_valid && !in_stall;
	assign out_load   = (state_q == S_LOAD && in_acc && echo) ||
	                    (state_q == S_EMIT_WAIT && out_free);
	assign count_full = count_q == lttb_pkg::CNT_W'(lttb_pkg::MAX_POINTS);
	assign n_new      = count_full ? count_q : count_q + lttb_pkg::CNT_W'(1);
	assign n_m1       = n_q - lttb_pkg::CNT_W'(1);
	assign eff        = (target_q > lttb_pkg::TGT_W'(lttb_pkg::MAX_KEPT)) ?
	                    lttb_pkg::TGT_W'(lttb_pkg::MAX_KEPT) : target_q;

	// A full store drops ordinary points; the last one overwrites the final slot.
	assign ram_we    = in_acc && !echo && (!count_full || is_last);
	assign ram_waddr = count_full ? lttb_pkg::ADDR_W'(lttb_pkg::MAX_POINTS - 1) :
	                   count_q[lttb_pkg::ADDR_W-1:0];

	assign mean_j   = (b2_q < n_q) ? b2_q[lttb_pkg::ADDR_W-1:0] : n_m1[lttb_pkg::ADDR_W-1:0];
	assign best_cap = (best_q >= n_q) ? n_m1 : best_q;

	always_comb begin
		unique case (state_q)
			S_MEAN_START:     ram_raddr = mean_j;
			S_MSUM, S_SC_RD:  ram_raddr = k_q[lttb_pkg::ADDR_W-1:0];
			default:          ram_raddr = emit_idx_q;
		endcase
	end

	// Bound i is floor(i*span/div)+1; the quotient advances by span/div and
	// the remainder carries into it when it reaches div.
	assign r_sum   = {1'b0, br_q} + {1'b0, rem_q};
	assign r_wrap  = r_sum >= {1'b0, div_q};
	assign br_nx   = r_wrap ? lttb_pkg::TGT_W'(r_sum - {1'b0, div_q}) :
	                 r_sum[lttb_pkg::TGT_W-1:0];
	assign bq_nx   = bq_q + lttb_pkg::ACC_W'(quo_q) + lttb_pkg::ACC_W'(r_wrap);
	assign bnd_raw = bq_q + lttb_pkg::ACC_W'(1);
	assign bnd_new = (bnd_raw > lttb_pkg::ACC_W'(n_q)) ? n_q : bnd_raw[lttb_pkg::CNT_W-1:0];

	// Restoring divider, one quotient bit per cycle for both dividends.
	assign dv_busy  = dv_cnt_q != lttb_pkg::DSTEP_W'(lttb_pkg::DIV_STEPS);
	assign ta       = {dv_ra_q, dv_a_q[lttb_pkg::SUM_W-1]};
	assign tb       = {dv_rb_q, dv_b_q[lttb_pkg::SUM_W-1]};
	assign ta_ge    = ta >= {1'b0, dv_d_q};
	assign tb_ge    = tb >= {1'b0, dv_d_q};
	assign dv_ra_nx = ta_ge ? lttb_pkg::CNT_W'(ta - {1'b0, dv_d_q}) : ta[lttb_pkg::CNT_W-1:0];
	assign dv_rb_nx = tb_ge ? lttb_pkg::CNT_W'(tb - {1'b0, dv_d_q}) : tb[lttb_pkg::CNT_W-1:0];

	// Cross product terms with signs tracked separately from magnitudes.
	assign d1   = (ax_q < mx_q) ? mx_q - ax_q : ax_q - mx_q;
	assign d2   = (rd_level < ay_q) ? ay_q - rd_level : rd_level - ay_q;
	assign d3   = (ax_q < rd_time) ? rd_time - ax_q : ax_q - rd_time;
	assign d4   = (my_q < ay_q) ? ay_q - my_q : my_q - ay_q;
	assign n1   = (ax_q < mx_q) != (rd_level < ay_q);
	assign n2   = (ax_q < rd_time) != (my_q < ay_q);
	assign m1_c = lttb_pkg::PROD_W'(d1) * lttb_pkg::PROD_W'(d2);
	assign m2_c = lttb_pkg::PROD_W'(d3) * lttb_pkg::PROD_W'(d4);

	always_comb begin
		if (neg_q) begin
			area = {1'b0, m1_q} + {1'b0, m2_q};
		end else if (m1_q >= m2_q) begin
			area = {1'b0, m1_q - m2_q};
		end else begin
			area = {1'b0, m2_q - m1_q};
		end
	end

	assign better = !have_q || (area > best_area_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			phase_q     <= PH_PASS;
			target_q    <= lttb_pkg::TGT_W'(lttb_pkg::TGT_RESET);
			count_q     <= '0;
			n_q         <= '0;
			div_q       <= '0;
			emit_idx_q  <= '0;
			emit_last_q <= 1'b0;
			out_valid_q <= 1'b0;
			sel_time_q  <= '0;
			sel_level_q <= '0;
			sel_last_q  <= 1'b0;
			ax_q        <= '0;
			ay_q        <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			bq_q        <= '0;
			br_q        <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			b0_q        <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			init_cnt_q  <= '0;
			bkt_q       <= '0;
			k_q         <= '0;
			pv_q        <= 1'b0;
			sum_t_q     <= '0;
			sum_l_q     <= '0;
			dv_a_q      <= '0;
			dv_b_q      <= '0;
			dv_ra_q     <= '0;
			dv_rb_q     <= '0;
			dv_d_q      <= '0;
			dv_cnt_q    <= '0;
			m1_q        <= '0;
			m2_q        <= '0;
			neg_q       <= 1'b0;
			have_q      <= 1'b0;
			best_q      <= '0;
			best_area_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (echo) begin
							out_valid_q <= 1'b1;
							sel_time_q  <= point_time;
							sel_level_q <= point_level;
							sel_last_q  <= is_last;
							count_q     <= '0;
						end else begin
							if (is_last) begin
								count_q     <= '0;
								n_q         <= n_new;
								div_q       <= eff - lttb_pkg::TGT_W'(2);
								emit_idx_q  <= '0;
								emit_last_q <= n_new == lttb_pkg::CNT_W'(1);
								phase_q     <= (n_new <= lttb_pkg::CNT_W'(eff)) ?
								               PH_PASS : PH_FIRST;
								state_q     <= S_EMIT_RD;
							end else if (!count_full) begin
								count_q <= count_q + lttb_pkg::CNT_W'(1);
							end
						end
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sel_time_q  <= rd_time;
						sel_level_q <= rd_level;
						sel_last_q  <= emit_last_q;
						ax_q        <= rd_time;
						ay_q        <= rd_level;
						unique case (phase_q)
							PH_PASS: begin
								if (emit_last_q) begin
									state_q <= S_LOAD;
								end else begin
									emit_idx_q  <= emit_idx_q + lttb_pkg::ADDR_W'(1);
									emit_last_q <= ({1'b0, emit_idx_q} +
									               lttb_pkg::CNT_W'(2)) == n_q;
									state_q     <= S_EMIT_RD;
								end
							end
							PH_FIRST: begin
								dv_a_q   <= lttb_pkg::SUM_W'(n_q - lttb_pkg::CNT_W'(2));
								dv_b_q   <= '0;
								dv_ra_q  <= '0;
								dv_rb_q  <= '0;
								dv_d_q   <= lttb_pkg::CNT_W'(div_q);
								dv_cnt_q <= '0;
								state_q  <= S_SETUP_DIV;
							end
							PH_INNER: begin
								bkt_q <= bkt_q + lttb_pkg::TGT_W'(1);
								if (bkt_q + lttb_pkg::TGT_W'(1) == div_q) begin
									emit_idx_q  <= n_m1[lttb_pkg::ADDR_W-1:0];
									emit_last_q <= 1'b1;
									phase_q     <= PH_FINAL;
									state_q     <= S_EMIT_RD;
								end else begin
									state_q <= S_NEXT;
								end
							end
							PH_FINAL: begin
								state_q <= S_LOAD;
							end
							default: begin
								state_q <= S_LOAD;
							end
						endcase
					end
				end
				S_SETUP_DIV: begin
					if (dv_busy) begin
						dv_a_q   <= {dv_a_q[lttb_pkg::SUM_W-2:0], ta_ge};
						dv_b_q   <= {dv_b_q[lttb_pkg::SUM_W-2:0], tb_ge};
						dv_ra_q  <= dv_ra_nx;
						dv_rb_q  <= dv_rb_nx;
						dv_cnt_q <= dv_cnt_q + lttb_pkg::DSTEP_W'(1);
					end else begin
						quo_q      <= dv_a_q[lttb_pkg::ADDR_W-1:0];
						rem_q      <= dv_ra_q[lttb_pkg::TGT_W-1:0];
						bq_q       <= '0;
						br_q       <= '0;
						init_cnt_q <= '0;
						bkt_q      <= '0;
						state_q    <= S_INIT_STEP;
					end
				end
				S_INIT_STEP: begin
					// Three steps fill the bounds of the first bucket and its neighbor.
					b0_q       <= b1_q;
					b1_q       <= b2_q;
					b2_q       <= bnd_new;
					bq_q       <= bq_nx;
					br_q       <= br_nx;
					init_cnt_q <= init_cnt_q + 2'd1;
					if (init_cnt_q == 2'd2) begin
						state_q <= S_MEAN_START;
					end
				end
				S_NEXT: begin
					b0_q    <= b1_q;
					b1_q    <= b2_q;
					b2_q    <= bnd_new;
					bq_q    <= bq_nx;
					br_q    <= br_nx;
					state_q <= S_MEAN_START;
				end
				S_MEAN_START: begin
					if (b2_q > b1_q) begin
						k_q     <= b1_q;
						pv_q    <= 1'b0;
						sum_t_q <= '0;
						sum_l_q <= '0;
						state_q <= S_MSUM;
					end else begin
						state_q <= S_MPT_WAIT;
					end
				end
				S_MPT_WAIT: begin
					// An empty next bucket uses the point at its end as its mean.
					mx_q    <= rd_time;
					my_q    <= rd_level;
					k_q     <= b0_q;
					have_q  <= 1'b0;
					best_q  <= b0_q;
					state_q <= S_SC_RD;
				end
				S_MSUM: begin
					if (pv_q) begin
						sum_t_q <= sum_t_q + lttb_pkg::SUM_W'(rd_time);
						sum_l_q <= sum_l_q + lttb_pkg::LSUM_W'(rd_level);
					end
					if (k_q < b2_q) begin
						k_q  <= k_q + lttb_pkg::CNT_W'(1);
						pv_q <= 1'b1;
					end else begin
						pv_q <= 1'b0;
						if (!pv_q) begin
							dv_a_q   <= sum_t_q;
							dv_b_q   <= lttb_pkg::SUM_W'(sum_l_q);
							dv_ra_q  <= '0;
							dv_rb_q  <= '0;
							dv_d_q   <= b2_q - b1_q;
							dv_cnt_q <= '0;
							state_q  <= S_MDIV;
						end
					end
				end
				S_MDIV: begin
					if (dv_busy) begin
						dv_a_q   <= {dv_a_q[lttb_pkg::SUM_W-2:0], ta_ge};
						dv_b_q   <= {dv_b_q[lttb_pkg::SUM_W-2:0], tb_ge};
						dv_ra_q  <= dv_ra_nx;
						dv_rb_q  <= dv_rb_nx;
						dv_cnt_q <= dv_cnt_q + lttb_pkg::DSTEP_W'(1);
					end else begin
						mx_q    <= dv_a_q[lttb_pkg::TIME_W-1:0];
						my_q    <= dv_b_q[lttb_pkg::LEVEL_W-1:0];
						k_q     <= b0_q;
						have_q  <= 1'b0;
						best_q  <= b0_q;
						state_q <= S_SC_RD;
					end
				end
				S_SC_RD: begin
					if (k_q < b1_q) begin
						state_q <= S_SC_MUL;
					end else begin
						emit_idx_q  <= best_cap[lttb_pkg::ADDR_W-1:0];
						emit_last_q <= 1'b0;
						phase_q     <= PH_INNER;
						state_q     <= S_EMIT_RD;
					end
				end
				S_SC_MUL: begin
					m1_q    <= m1_c;
					m2_q    <= m2_c;
					neg_q   <= n1 != n2;
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					// Strictly larger wins, so ties keep the earliest point.
					if (better) begin
						have_q      <= 1'b1;
						best_area_q <= area;
						best_q      <= k_q;
					end
					k_q     <= k_q + lttb_pkg::CNT_W'(1);
					state_q <= S_SC_RD;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sel_time  = sel_time_q;
	assign sel_level = sel_level_q;
	assign sel_last  = sel_last_q;

endmodule

>>> sv/lttb_checker.sv
// Port-level checker for lttb_downsampler_unit, bound to the top level.
// Depends on lttb_pkg for field widths.
module lttb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_wr_en,
	input logic [lttb_pkg::TGT_W-1:0]   cfg_wr_data,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [lttb_pkg::TIME_W-1:0]  point_time,
	input logic [lttb_pkg::LEVEL_W-1:0] point_level,
	input logic                         is_last,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [lttb_pkg::TIME_W-1:0]  sel_time,
	input logic [lttb_pkg::LEVEL_W-1:0] sel_level,
	input logic                         sel_last
);

	// Leaving reset, the block is empty and ready for a request.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not idle after reset");

	// The input only stalls after a series ends or while an echoed point is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall && is_last) ||
		                    (out_valid && out_stall))
		else $error("input stalled without cause");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sel_time) && $stable(sel_level) &&
		                           $stable(sel_last))
		else $error("output payload changed while stalled");

endmodule

bind lttb_downsampler_unit lttb_checker u_lttb_checker (.*);
